FILE: rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants of the bounded bag store.
// ----------------------------------------------------------------------------
package bbs_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

FILE: rtl/bbs_ctrl.sv
// ----------------------------------------------------------------------------
// bbs_ctrl
// Request sequencer: takes a request, starts its execution, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module bbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bbs_pkg::dp_cmd_t cmd
);
	import bbs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					cmd.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/bbs_dp.sv
// ----------------------------------------------------------------------------
// bbs_dp
// Entry cells with parallel compare and shift, count and capacity registers,
// and the result register.
// ----------------------------------------------------------------------------
module bbs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbs_pkg::dp_cmd_t               cmd,
	input  logic                           cfg_we,
	input  logic [bbs_pkg::CAP_W-1:0]      cfg_data,
	input  logic [1:0]                     req_type,
	input  logic signed [bbs_pkg::DATA_W-1:0] value_in,
	output logic                           success,
	output logic [bbs_pkg::IDX_W-1:0]      match_index,
	output logic signed [bbs_pkg::DATA_W-1:0] value_out,
	output logic [bbs_pkg::CNT_W-1:0]      entry_count,
	output logic                           is_empty
);
	import bbs_pkg::*;

	req_t              req_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;

	logic              success_q;
	logic [IDX_W-1:0]  match_index_q;
	logic [DATA_W-1:0] value_out_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic              is_empty_q;

	logic [DEPTH-1:0]  hit;
	logic              found;
	logic [IDX_W-1:0]  pos;
	logic [CAP_W-1:0]  eff_cap;
	logic              ins_ok;
	logic              rem_ok;
	logic [CNT_W-1:0]  count_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(req_type);
			val_q <= value_in;
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit[i] = (CNT_W'(i) < count_q) && (entries_q[i] == val_q);
		end
	end

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				pos   = IDX_W'(i);
			end
		end
	end

	assign eff_cap = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
	assign ins_ok  = (req_q == REQ_INSERT) && (CAP_W'(count_q) < eff_cap);
	assign rem_ok  = (req_q == REQ_REMOVE) && found;

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (ins_ok && (count_q[IDX_W-1:0] == IDX_W'(i))) begin
					entries_q[i] <= val_q;
				end else if (rem_ok && (i < DEPTH - 1) && (IDX_W'(i) >= pos)) begin
					entries_q[i] <= entries_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			unique case (req_q)
				REQ_INSERT: begin
					success_q     <= ins_ok;
					match_index_q <= '0;
				end
				REQ_REMOVE, REQ_QUERY: begin
					success_q     <= found;
					match_index_q <= found ? pos : '0;
				end
				default: begin
					success_q     <= 1'b0;
					match_index_q <= '0;
				end
			endcase
			// The removed entry equals the key, so the key is returned.
			value_out_q   <= rem_ok ? val_q : '0;
			entry_count_q <= count_d;
			is_empty_q    <= (count_d == '0);
		end
	end

	assign success     = success_q;
	assign match_index = match_index_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule

FILE: rtl/bounded_bag_store_top.sv
// Flow: an accepted request is loaded in IDLE and executed in EXEC once the
// output register is free; a stalled result delays execution of the next request.
// One request at a time: the sequencer takes a request, then executes it over
// all entry cells, compare and shift in parallel.
// A finished result waits in the output register while the next request is taken.
// Reset clears the entry count to zero and the capacity limit to 16; entry
// contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// bounded_bag_store_top
// Bounded unordered store of signed values with insert, remove and query.
// ----------------------------------------------------------------------------
module bounded_bag_store_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbs_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic signed [bbs_pkg::DATA_W-1:0] value_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              success,
	output logic [bbs_pkg::IDX_W-1:0]         match_index,
	output logic signed [bbs_pkg::DATA_W-1:0] value_out,
	output logic [bbs_pkg::CNT_W-1:0]         entry_count,
	output logic                              is_empty
);
	import bbs_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bbs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.value_in    (value_in),
		.success     (success),
		.match_index (match_index),
		.value_out   (value_out),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("A request was taken while another was executing.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(DEPTH)))
		else $error("Entry count exceeds the store depth.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("Empty flag disagrees with the entry count.");

endmodule
